FILE: sv/assert_macros.svh
// Assertion macros shared by the linear gradient shader modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define LGS_ASSERT(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (cond)) else $error(msg);

// Checks that a condition implies another at the same clock edge.
`define LGS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) else $error(msg);

`endif

FILE: sv/lgs_pkg.sv
// Package of the linear gradient shader: sizes, codes and stage types.
// Depends on nothing; used by every module of the shader.
package lgs_pkg;

  localparam int MAX_STOPS   = 16;
  localparam int COORD_BITS  = 12;
  localparam int STOP_IDX_W  = $clog2(MAX_STOPS);
  localparam int STOP_CNT_W  = 5;

  localparam int PROD_W      = 32 + COORD_BITS + 2;
  localparam int SUM_W       = PROD_W + 2;
  localparam int T_W         = SUM_W - 1;
  localparam int U_W         = 17;
  localparam int W_W         = 16;
  localparam int P_W         = U_W + STOP_IDX_W;
  localparam int C16_W       = 24;
  localparam int PP_W        = 2 * C16_W;

  localparam logic [U_W-1:0] ONE_Q16 = U_W'(65536);
  localparam logic [U_W:0]   TWO_Q16 = (U_W + 1)'(131072);

  localparam int FIFO_DEPTH  = 16;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_SHADE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    TILE_CLAMP  = 2'd0,
    TILE_REPEAT = 2'd1,
    TILE_MIRROR = 2'd2
  } tile_t;

  typedef enum logic [2:0] {
    REG_COEF_X      = 3'd0,
    REG_COEF_Y      = 3'd1,
    REG_COEF_OFFSET = 3'd2,
    REG_STOP_COUNT  = 3'd3,
    REG_TILE_MODE   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic                  valid;
    logic                  shade;
    logic                  wr_ok;
    logic [STOP_IDX_W-1:0] wr_idx;
    logic [31:0]           wr_data;
    logic [U_W-1:0]        u;
  } tile_stage_t;

  typedef struct packed {
    logic           valid;
    logic [W_W-1:0] w;
  } blend_stage_t;

endpackage

FILE: sv/lgs_param.sv
// Gradient parameter pipeline: coordinates to tiled parameter in Q1.16.
// Depends on lgs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lgs_param (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic                           command,
  input  logic [3:0]                     stop_index,
  input  logic [31:0]                    stop_color,
  input  logic [lgs_pkg::COORD_BITS-1:0] x_in,
  input  logic [lgs_pkg::COORD_BITS-1:0] y_in,
  input  logic signed [31:0]             coef_x,
  input  logic signed [31:0]             coef_y,
  input  logic signed [31:0]             coef_offset,
  input  logic [1:0]                     tile_mode,
  output lgs_pkg::tile_stage_t           ts
);

  logic                                  v1;
  logic                                  v2;
  logic                                  v3;
  logic                                  shade1;
  logic                                  shade2;
  logic                                  shade3;
  logic                                  ok1;
  logic                                  ok2;
  logic                                  ok3;
  logic [lgs_pkg::STOP_IDX_W-1:0]        idx1;
  logic [lgs_pkg::STOP_IDX_W-1:0]        idx2;
  logic [lgs_pkg::STOP_IDX_W-1:0]        idx3;
  logic [31:0]                           col1;
  logic [31:0]                           col2;
  logic [31:0]                           col3;
  logic [lgs_pkg::COORD_BITS-1:0]        x1;
  logic [lgs_pkg::COORD_BITS-1:0]        y1;
  logic signed [lgs_pkg::PROD_W-1:0]     px;
  logic signed [lgs_pkg::PROD_W-1:0]     py;
  logic signed [lgs_pkg::SUM_W-1:0]      sum;
  logic signed [lgs_pkg::T_W-1:0]        t;
  logic [lgs_pkg::U_W-1:0]               m;
  logic [lgs_pkg::U_W-1:0]               u_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      ts.valid <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      ts.valid <= v3;
    end

    shade1 <= (command == lgs_pkg::CMD_SHADE);
    ok1 <= (32'(stop_index) < 32'(lgs_pkg::MAX_STOPS));
    idx1 <= lgs_pkg::STOP_IDX_W'(stop_index);
    col1 <= stop_color;
    x1 <= x_in;
    y1 <= y_in;

    shade2 <= shade1;
    ok2 <= ok1;
    idx2 <= idx1;
    col2 <= col1;
    px <= lgs_pkg::PROD_W'(coef_x) * lgs_pkg::PROD_W'($signed({1'b0, x1, 1'b1}));
    py <= lgs_pkg::PROD_W'(coef_y) * lgs_pkg::PROD_W'($signed({1'b0, y1, 1'b1}));

    shade3 <= shade2;
    ok3 <= ok2;
    idx3 <= idx2;
    col3 <= col2;
    t <= sum[lgs_pkg::SUM_W-1:1];

    ts.shade <= shade3;
    ts.wr_ok <= ok3;
    ts.wr_idx <= idx3;
    ts.wr_data <= col3;
    ts.u <= u_next;
  end

  // Twice the parameter; the arithmetic shift above halves it with floor.
  assign sum = lgs_pkg::SUM_W'(px) + lgs_pkg::SUM_W'(py)
             + (lgs_pkg::SUM_W'(coef_offset) <<< 1);

  assign m = t[lgs_pkg::U_W-1:0];

  always_comb begin
    case (tile_mode)
      lgs_pkg::TILE_CLAMP: begin
        if (t[lgs_pkg::T_W-1]) begin
          u_next = '0;
        end else if (t > $signed(lgs_pkg::T_W'(lgs_pkg::ONE_Q16))) begin
          u_next = lgs_pkg::ONE_Q16;
        end else begin
          u_next = m;
        end
      end
      lgs_pkg::TILE_REPEAT: begin
        u_next = {1'b0, m[lgs_pkg::W_W-1:0]};
      end
      default: begin
        if (m > lgs_pkg::ONE_Q16) begin
          u_next = lgs_pkg::U_W'(lgs_pkg::TWO_Q16 - {1'b0, m});
        end else begin
          u_next = m;
        end
      end
    endcase
  end

  `LGS_ASSERT_IMP(a_u_in_range, clk, rst, ts.valid && ts.shade, ts.u <= lgs_pkg::ONE_Q16, "tiled parameter above one")

endmodule

FILE: sv/lgs_stop_ram.sv
// Color stop table: synchronous memory, one write port, two read ports.
// Depends on lgs_pkg.
module lgs_stop_ram (
  input  logic                           clk,
  input  logic                           we,
  input  logic [lgs_pkg::STOP_IDX_W-1:0] waddr,
  input  logic [31:0]                    wdata,
  input  logic [lgs_pkg::STOP_IDX_W-1:0] raddr_a,
  input  logic [lgs_pkg::STOP_IDX_W-1:0] raddr_b,
  output logic [31:0]                    rdata_a,
  output logic [31:0]                    rdata_b
);

  logic [31:0] mem [lgs_pkg::MAX_STOPS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: sv/lgs_blend.sv
// Channel interpolation, premultiplication and rounding to ARGB8888.
// Depends on lgs_pkg.
module lgs_blend (
  input  logic                  clk,
  input  logic                  rst,
  input  lgs_pkg::blend_stage_t bs,
  input  logic [31:0]           left_color,
  input  logic [31:0]           right_color,
  output logic                  push,
  output logic [31:0]           push_data
);

  logic                                  v6;
  logic [3:0][lgs_pkg::C16_W-1:0]        c16_next;
  logic [3:0][lgs_pkg::C16_W-1:0]        c16;
  logic [lgs_pkg::U_W-1:0]               inv_w;
  logic [7:0]                            alpha;
  logic [2:0][lgs_pkg::PP_W-1:0]         prod;
  logic [2:0][lgs_pkg::PP_W:0]           biased;
  logic [2:0][15:0]                      hi;
  logic [2:0][15:0]                      quot;

  assign inv_w = lgs_pkg::ONE_Q16 - lgs_pkg::U_W'(bs.w);

  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      c16_next[ch] = lgs_pkg::C16_W'(
          lgs_pkg::C16_W'(left_color[ch*8 +: 8]) * lgs_pkg::C16_W'(inv_w)
        + lgs_pkg::C16_W'(right_color[ch*8 +: 8]) * lgs_pkg::C16_W'(bs.w));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      push <= 1'b0;
    end else begin
      v6 <= bs.valid;
      push <= v6;
    end
  end

  always_ff @(posedge clk) begin
    c16 <= c16_next;
    alpha <= 8'((c16[3] + lgs_pkg::C16_W'(32768)) >> 16);
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] <= lgs_pkg::PP_W'(c16[ch]) * lgs_pkg::PP_W'(c16[3]);
    end
  end

  // Rounded division by 255 * 2^32: shift out 2^32, then divide by 255
  // with the reciprocal identity that is exact below 65535.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      biased[ch] = (lgs_pkg::PP_W + 1)'(prod[ch])
                 + (lgs_pkg::PP_W + 1)'(64'd255 << 31);
      hi[ch] = biased[ch][47:32];
      quot[ch] = hi[ch] + 16'd1 + (hi[ch] >> 8);
    end
  end

  assign push_data = {alpha, quot[2][15:8], quot[1][15:8], quot[0][15:8]};

endmodule

FILE: sv/lgs_out_fifo.sv
// Output queue that holds finished pixels while the consumer stalls.
// Depends on lgs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lgs_out_fifo (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [31:0] push_data,
  input  logic        pop,
  output logic        not_empty,
  output logic [31:0] head
);

  logic [31:0]                      mem [lgs_pkg::FIFO_DEPTH];
  logic [lgs_pkg::FIFO_PTR_W-1:0]   wr_ptr;
  logic [lgs_pkg::FIFO_PTR_W-1:0]   rd_ptr;
  logic [lgs_pkg::FIFO_CNT_W-1:0]   count;
  logic                             full;

  assign not_empty = (count != '0);
  assign full = (count == lgs_pkg::FIFO_CNT_W'(lgs_pkg::FIFO_DEPTH));
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + lgs_pkg::FIFO_CNT_W'(push) - lgs_pkg::FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  `LGS_ASSERT(a_no_overflow, clk, rst, !(push && full && !pop), "pixel queue overflow")
  `LGS_ASSERT_IMP(a_no_underflow, clk, rst, pop, not_empty, "pop from empty pixel queue")

endmodule

FILE: sv/linear_gradient_shader.sv
// Linear gradient shader: one pixel or stop word accepted per cycle while in_stall is low.
// A shaded pixel passes the parameter pipeline, the stop table and the blend stages into the output queue.
// The stop table reads both stops in the same cycle.
// Input stalls only when 16 pixels are in flight or queued behind a stalled output.
// Reset clears the registers to their defaults and empties the pipeline and queue.
// Depends on lgs_pkg, lgs_param, lgs_stop_ram, lgs_blend, lgs_out_fifo, assert_macros.svh.
`include "assert_macros.svh"

module linear_gradient_shader (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [3:0]  stop_index,
  input  logic [31:0] stop_color,
  input  logic [11:0] pixel_x,
  input  logic [11:0] pixel_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] pixel_color
);

  logic signed [31:0]                    coef_x;
  logic signed [31:0]                    coef_y;
  logic signed [31:0]                    coef_offset;
  logic [lgs_pkg::STOP_CNT_W-1:0]        stop_count;
  logic [1:0]                            tile_mode;
  logic                                  cfg_write;
  logic                                  in_accept;
  logic                                  out_accept;
  logic [lgs_pkg::FIFO_CNT_W-1:0]        credits;
  lgs_pkg::tile_stage_t                  ts;
  lgs_pkg::blend_stage_t                 bs;
  logic [lgs_pkg::STOP_CNT_W-1:0]        n_sat;
  logic [lgs_pkg::STOP_IDX_W-1:0]        nm1;
  logic [lgs_pkg::P_W-1:0]               p;
  logic [lgs_pkg::STOP_IDX_W-1:0]        left_idx;
  logic [lgs_pkg::STOP_IDX_W-1:0]        right_idx;
  logic [31:0]                           left_color;
  logic [31:0]                           right_color;
  logic                                  push;
  logic [31:0]                           push_data;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_x <= '0;
      coef_y <= '0;
      coef_offset <= '0;
      stop_count <= lgs_pkg::STOP_CNT_W'(2);
      tile_mode <= lgs_pkg::TILE_CLAMP;
    end else if (cfg_write) begin
      case (paddr[4:2])
        lgs_pkg::REG_COEF_X:      coef_x <= pwdata;
        lgs_pkg::REG_COEF_Y:      coef_y <= pwdata;
        lgs_pkg::REG_COEF_OFFSET: coef_offset <= pwdata;
        lgs_pkg::REG_STOP_COUNT:  stop_count <= pwdata[lgs_pkg::STOP_CNT_W-1:0];
        lgs_pkg::REG_TILE_MODE:   tile_mode <= pwdata[1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      lgs_pkg::REG_COEF_X:      prdata = coef_x;
      lgs_pkg::REG_COEF_Y:      prdata = coef_y;
      lgs_pkg::REG_COEF_OFFSET: prdata = coef_offset;
      lgs_pkg::REG_STOP_COUNT:  prdata = 32'(stop_count);
      lgs_pkg::REG_TILE_MODE:   prdata = 32'(tile_mode);
      default:                  prdata = '0;
    endcase
  end

  assign in_stall = (credits == lgs_pkg::FIFO_CNT_W'(lgs_pkg::FIFO_DEPTH));
  assign in_accept = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits
               + lgs_pkg::FIFO_CNT_W'(in_accept && (command == lgs_pkg::CMD_SHADE))
               - lgs_pkg::FIFO_CNT_W'(out_accept);
    end
  end

  lgs_param u_param (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .command     (command),
    .stop_index  (stop_index),
    .stop_color  (stop_color),
    .x_in        (pixel_x[lgs_pkg::COORD_BITS-1:0]),
    .y_in        (pixel_y[lgs_pkg::COORD_BITS-1:0]),
    .coef_x      (coef_x),
    .coef_y      (coef_y),
    .coef_offset (coef_offset),
    .tile_mode   (tile_mode),
    .ts          (ts)
  );

  always_comb begin
    if (stop_count == '0) begin
      n_sat = lgs_pkg::STOP_CNT_W'(1);
    end else if (stop_count > lgs_pkg::STOP_CNT_W'(lgs_pkg::MAX_STOPS)) begin
      n_sat = lgs_pkg::STOP_CNT_W'(lgs_pkg::MAX_STOPS);
    end else begin
      n_sat = stop_count;
    end
  end

  assign nm1 = lgs_pkg::STOP_IDX_W'(n_sat - 1'b1);
  assign p = lgs_pkg::P_W'(ts.u) * lgs_pkg::P_W'(nm1);
  assign left_idx = p[lgs_pkg::W_W +: lgs_pkg::STOP_IDX_W];
  assign right_idx = (left_idx == nm1) ? left_idx : left_idx + 1'b1;

  // Stop writes and stop reads share this stage, so they keep word order.
  lgs_stop_ram u_stop_ram (
    .clk     (clk),
    .we      (ts.valid && !ts.shade && ts.wr_ok),
    .waddr   (ts.wr_idx),
    .wdata   (ts.wr_data),
    .raddr_a (left_idx),
    .raddr_b (right_idx),
    .rdata_a (left_color),
    .rdata_b (right_color)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bs.valid <= 1'b0;
    end else begin
      bs.valid <= ts.valid && ts.shade;
    end
    bs.w <= p[lgs_pkg::W_W-1:0];
  end

  lgs_blend u_blend (
    .clk         (clk),
    .rst         (rst),
    .bs          (bs),
    .left_color  (left_color),
    .right_color (right_color),
    .push        (push),
    .push_data   (push_data)
  );

  lgs_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (out_accept),
    .not_empty (out_valid),
    .head      (pixel_color)
  );

  `LGS_ASSERT(a_credit_bound, clk, rst, credits <= lgs_pkg::FIFO_CNT_W'(lgs_pkg::FIFO_DEPTH), "pixel credits above queue depth")
  `LGS_ASSERT_IMP(a_out_has_credit, clk, rst, out_valid, credits != '0, "output word without credit")

endmodule

FILE: bench/tb_linear_gradient_shader.sv
`timescale 1ns / 100ps
// Self-checking testbench for linear_gradient_shader: drives stop loads and pixels
// with random gaps and stalls, and predicts every premultiplied pixel in a scoreboard.
// Depends on lgs_pkg and the shader RTL.
module tb_linear_gradient_shader;

  localparam logic [1:0] TILE_ALIAS_MIRROR = 2'd3;
  localparam logic [31:0] EDGE_STOPS [6] = '{32'hFFFFFFFF, 32'h00000000, 32'hFF000000,
                                             32'h00FFFFFF, 32'h80FF8000, 32'h7F00FF7F};
  localparam logic [11:0] PROBE_X [9] = '{12'd0, 12'd4095, 12'd4095, 12'd0, 12'd2048,
                                          12'd1024, 12'd2047, 12'd1, 12'd3000};
  localparam logic [11:0] PROBE_Y [9] = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd2047,
                                          12'd1024, 12'd2048, 12'd1, 12'd100};

  class pixel_scoreboard;
    logic signed [31:0] coef_x;
    logic signed [31:0] coef_y;
    logic signed [31:0] coef_offset;
    logic [4:0] stop_count;
    logic [1:0] tile_mode;
    logic [31:0] stop_table [lgs_pkg::MAX_STOPS];
    logic [31:0] pending_pixels [$];
    int errors;

    function new();
      coef_x = 32'sd0;
      coef_y = 32'sd0;
      coef_offset = 32'sd0;
      stop_count = 5'd2;
      tile_mode = lgs_pkg::TILE_CLAMP;
      errors = 0;
    endfunction

    function void write_reg(lgs_pkg::reg_idx_t r, logic [31:0] v);
      case (r)
        lgs_pkg::REG_COEF_X: coef_x = v;
        lgs_pkg::REG_COEF_Y: coef_y = v;
        lgs_pkg::REG_COEF_OFFSET: coef_offset = v;
        lgs_pkg::REG_STOP_COUNT: stop_count = v[4:0];
        lgs_pkg::REG_TILE_MODE: tile_mode = v[1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] gradient_color(logic [11:0] x, logic [11:0] y);
      longint sum, t, m, xs, ys;
      longint unsigned c16, a16, den;
      int unsigned n, u, p, lo, hi, w;
      logic [7:0] byte_l, byte_r;
      logic [31:0] pix;
      xs = longint'(x);
      ys = longint'(y);
      sum = longint'(coef_x) * (2 * xs + 1) + longint'(coef_y) * (2 * ys + 1)
            + 2 * longint'(coef_offset);
      t = sum >>> 1;
      case (lgs_pkg::tile_t'(tile_mode))
        lgs_pkg::TILE_CLAMP: u = (t < 0) ? 0 : ((t > 65536) ? 65536 : int'(t));
        lgs_pkg::TILE_REPEAT: u = int'(t & 64'hFFFF);
        default: begin
          m = t & 64'h1FFFF;
          if (m > 65536) m = 131072 - m;
          u = int'(m);
        end
      endcase
      n = 32'(stop_count);
      if (n < 1) n = 1;
      if (n > lgs_pkg::MAX_STOPS) n = lgs_pkg::MAX_STOPS;
      p = u * (n - 1);
      lo = p >> 16;
      w = p & 32'hFFFF;
      if (lo > n - 1) lo = n - 1;
      hi = (lo + 1 > n - 1) ? n - 1 : lo + 1;
      den = 64'd255 << 32;
      a16 = 0;
      pix = 0;
      for (int k = 3; k >= 0; k--) begin
        byte_l = 8'(stop_table[lo] >> (8 * k));
        byte_r = 8'(stop_table[hi] >> (8 * k));
        c16 = 64'(byte_l) * 64'(65536 - w) + 64'(byte_r) * 64'(w);
        if (k == 3) begin
          a16 = c16;
          pix[31:24] = 8'((c16 + 32768) >> 16);
        end else begin
          pix[8*k +: 8] = 8'((c16 * a16 + den / 2) / den);
        end
      end
      return pix;
    endfunction

    function void note_word(lgs_pkg::cmd_t cmd, logic [3:0] idx, logic [31:0] color,
                            logic [11:0] x, logic [11:0] y);
      if (cmd == lgs_pkg::CMD_LOAD) stop_table[idx] = color;
      else pending_pixels.push_back(gradient_color(x, y));
    endfunction

    function void check_pixel(logic [31:0] got);
      logic [31:0] want;
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel: expected none, got %08h", $time, got);
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: pixel_color mismatch: expected %08h, got %08h", $time, want, got);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = lgs_pkg::CMD_LOAD;
  logic [3:0] stop_index = '0;
  logic [31:0] stop_color = '0;
  logic [11:0] pixel_x = '0;
  logic [11:0] pixel_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] pixel_color;
  bit calm = 1'b0;
  pixel_scoreboard sb = new();

  linear_gradient_shader dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .command(command),
    .stop_index(stop_index), .stop_color(stop_color), .pixel_x(pixel_x),
    .pixel_y(pixel_y), .out_valid(out_valid), .out_stall(out_stall),
    .pixel_color(pixel_color)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_pixel(pixel_color);
    out_stall <= !calm && ($urandom_range(99) < 8);
  end

  task automatic apb_write(lgs_pkg::reg_idx_t r, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(r, v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] cx, logic [31:0] cy, logic [31:0] off,
                            logic [4:0] n, logic [1:0] mode);
    apb_write(lgs_pkg::REG_COEF_X, cx);
    apb_write(lgs_pkg::REG_COEF_Y, cy);
    apb_write(lgs_pkg::REG_COEF_OFFSET, off);
    apb_write(lgs_pkg::REG_STOP_COUNT, {27'd0, n});
    apb_write(lgs_pkg::REG_TILE_MODE, {30'd0, mode});
  endtask

  task automatic send_word(lgs_pkg::cmd_t cmd, logic [3:0] idx, logic [31:0] color,
                           logic [11:0] x, logic [11:0] y);
    while (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    stop_index <= idx;
    stop_color <= color;
    pixel_x <= x;
    pixel_y <= y;
    do @(posedge clk); while (in_stall);
    sb.note_word(cmd, idx, color, x, y);
  endtask

  task automatic run_words(int count);
    logic [31:0] color;
    for (int i = 0; i < count; i++) begin
      color = $urandom;
      case ($urandom_range(3))
        0: color[31:24] = 8'h00;
        1: color[31:24] = 8'hFF;
        default: ;
      endcase
      if ($urandom_range(99) < 15)
        send_word(lgs_pkg::CMD_LOAD, 4'($urandom_range(15)), color,
                  12'($urandom), 12'($urandom));
      else
        send_word(lgs_pkg::CMD_SHADE, 4'($urandom), color, 12'($urandom), 12'($urandom));
    end
  endtask

  // Pixels still in the pipe must all come out, and stop loads behind them settle,
  // before any register changes.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coef();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 5) return $urandom_range(64) - 32;
    if (sel < 8) return $urandom_range(2048) - 1024;
    if (sel == 8) return $urandom;
    return ($urandom_range(1) == 0) ? 32'h7FFFFFFF : 32'h80000000;
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_config(32'd16, 32'd16, -32'sd32768, 5'd16, lgs_pkg::TILE_CLAMP);
    for (int i = 0; i < lgs_pkg::MAX_STOPS; i++)
      send_word(lgs_pkg::CMD_LOAD, 4'(i), (i < 6) ? EDGE_STOPS[i] : $urandom,
                12'($urandom), 12'($urandom));
    for (int i = 0; i < 9; i++)
      send_word(lgs_pkg::CMD_SHADE, 4'($urandom), $urandom, PROBE_X[i], PROBE_Y[i]);
    drain();
    set_config(32'h7FFFFFFF, 32'h80000000, 32'h0, 5'd31, lgs_pkg::TILE_REPEAT);
    run_words(20);
    drain();
    set_config(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 5'd0, lgs_pkg::TILE_MIRROR);
    run_words(20);
    drain();
    set_config(-32'sd16, 32'd8, 32'h80000000, 5'd17, TILE_ALIAS_MIRROR);
    run_words(20);
    drain();
    set_config(32'd24, -32'sd24, 32'd65536, 5'd1, lgs_pkg::TILE_MIRROR);
    run_words(20);
    drain();
    for (int ph = 0; ph < 13; ph++) begin
      calm = (ph == 6);
      set_config(pick_coef(), pick_coef(),
                 ($urandom_range(3) == 0) ? $urandom : $urandom_range(262143) - 131072,
                 5'(($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(16, 1)),
                 2'($urandom_range(3)));
      run_words(80);
      drain();
    end
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
